// ----- design/mandelbrot_escape_time_top_defines.svh -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Shared concurrent check wrappers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MET_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mandelbrot escape time: check failed");

// next-cycle implication
`define MET_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mandelbrot escape time: check failed");

`else

`define MET_ASSERT_IMP(label, clk, rst, ante, cons)
`define MET_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/met_pkg.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Constants shared by the iteration controller and the multiplier cells.
// ----------------------------------------------------------------------------
package met_pkg;

   // operand digit width handled by one multiplier cell
   localparam int DIG_BITS = 18;

   // escape radius squared, integer part
   localparam int ESC_LIMIT_INT = 4;

   // escape at feed k reports k minus this bias
   localparam logic [8:0] ESC_BIAS = 9'd2;

   localparam logic [7:0] MAX_ITER_RESET = 8'd100;

endpackage

// ----- design/met_cell.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot multiplier cell
// One digit slice of the x*x, y*y and x*y products; accumulates its partial
// products onto the running sums and hands everything to the next cell.
// ----------------------------------------------------------------------------
module met_cell
   import met_pkg::*;
#(
   parameter int WIDTH = 35,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [WIDTH-1:0]   in_x,
   input  logic signed [WIDTH-1:0]   in_y,
   input  logic signed [2*WIDTH-1:0] in_xx,
   input  logic signed [2*WIDTH-1:0] in_yy,
   input  logic signed [2*WIDTH-1:0] in_xy,
   output logic                      out_valid,
   output logic signed [WIDTH-1:0]   out_x,
   output logic signed [WIDTH-1:0]   out_y,
   output logic signed [2*WIDTH-1:0] out_xx,
   output logic signed [2*WIDTH-1:0] out_yy,
   output logic signed [2*WIDTH-1:0] out_xy
);

   localparam int NUM   = (WIDTH + DIG_BITS - 1) / DIG_BITS;
   localparam int ACC   = 2 * WIDTH;
   localparam int SHIFT = DIG_BITS * INDEX;
   localparam int PRODW = WIDTH + DIG_BITS + 1;
   localparam bit LAST  = (INDEX == NUM - 1);

   logic signed [WIDTH-1:0]    x_sh;
   logic signed [WIDTH-1:0]    y_sh;
   logic signed [DIG_BITS:0]   dx;
   logic signed [DIG_BITS:0]   dy;
   logic signed [PRODW-1:0]    p_xx;
   logic signed [PRODW-1:0]    p_yy;
   logic signed [PRODW-1:0]    p_xy;

   logic                       valid_ff, valid_in;
   logic signed [WIDTH-1:0]    x_ff, x_in;
   logic signed [WIDTH-1:0]    y_ff, y_in;
   logic signed [ACC-1:0]      xx_ff, xx_in;
   logic signed [ACC-1:0]      yy_ff, yy_in;
   logic signed [ACC-1:0]      xy_ff, xy_in;

   // lower digits are unsigned, the top digit carries the sign
   always_comb begin
      x_sh = in_x >>> SHIFT;
      y_sh = in_y >>> SHIFT;
      if (LAST) begin
         dx = x_sh[DIG_BITS:0];
         dy = y_sh[DIG_BITS:0];
      end else begin
         dx = {1'b0, x_sh[DIG_BITS-1:0]};
         dy = {1'b0, y_sh[DIG_BITS-1:0]};
      end
      p_xx = in_x * dx;
      p_yy = in_y * dy;
      p_xy = in_x * dy;
   end

   // sums wrap mod 2^ACC; the finished products fit
   always_comb begin
      valid_in = in_valid;
      x_in     = in_x;
      y_in     = in_y;
      xx_in    = in_xx + (ACC'(p_xx) <<< SHIFT);
      yy_in    = in_yy + (ACC'(p_yy) <<< SHIFT);
      xy_in    = in_xy + (ACC'(p_xy) <<< SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      xy_ff <= xy_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_xx    = xx_ff;
   assign out_yy    = yy_ff;
   assign out_xy    = xy_ff;

endmodule

// ----- design/mandelbrot_escape_time_top.sv -----
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Iterates z = z*z + c for one point and reports the escape pass count.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per point, cx in tdata[31:0], cy in tdata[63:32],
//   both signed fixed point with FRAC_BITS fraction bits.
//   rsp channel: one word per point, escape_count (9-bit signed) in
//   tdata[8:0]; -1 means escape on the first pass, max_iterations means the
//   point never escaped.
//   csr channel: 8-bit max_iterations, always ready; write only while idle.
//   One point is in flight at a time. Each pass runs through a chain of
//   NUM multiplier cells (NUM = ceil(width/18), 2 at the default width) and
//   then through the iterate update registers. req_tready goes high again in
//   the cycle the result is presented. If the receiver stalls, the finished
//   count waits in a holding register and no new point is taken until the
//   output register frees up. Reset returns to idle, drops rsp_tvalid and
//   sets max_iterations to 100.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_top_defines.svh"

module mandelbrot_escape_time_top
   import met_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] cx, [63:32] cy
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] escape_count, [15:9] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int XW   = (FRAC_BITS + 7 > 34) ? FRAC_BITS + 7 : 34;
   localparam int NUM  = (XW + DIG_BITS - 1) / DIG_BITS;
   localparam int ACC  = 2 * XW;
   localparam int SW   = ACC - FRAC_BITS;
   localparam int SW1  = SW + 1;
   localparam logic signed [SW:0] LIMIT = SW1'(ESC_LIMIT_INT) <<< FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type               state_ff, state_in;
   logic                    issue_ff, issue_in;
   logic [7:0]              max_iter_ff, max_iter_in;
   logic [7:0]              k_ff, k_in;
   logic signed [XW-1:0]    x_ff, x_in;
   logic signed [XW-1:0]    y_ff, y_in;
   logic signed [XW-1:0]    cx_ff, cx_in;
   logic signed [XW-1:0]    cy_ff, cy_in;
   logic [8:0]              res_ff, res_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [8:0]              rsp_count_ff, rsp_count_in;

   logic [NUM:0]            ch_valid;
   logic signed [XW-1:0]    ch_x  [NUM+1];
   logic signed [XW-1:0]    ch_y  [NUM+1];
   logic signed [ACC-1:0]   ch_xx [NUM+1];
   logic signed [ACC-1:0]   ch_yy [NUM+1];
   logic signed [ACC-1:0]   ch_xy [NUM+1];

   logic signed [ACC-1:0]   sq_xx_full;
   logic signed [ACC-1:0]   sq_yy_full;
   logic signed [ACC-1:0]   xy2_full;
   logic signed [SW-1:0]    xx_w;
   logic signed [SW-1:0]    yy_w;
   logic signed [SW:0]      xy2_w;
   logic signed [SW:0]      sum_w;
   logic signed [SW:0]      nx_w;
   logic signed [SW:0]      ny_w;
   logic                    escape;
   logic                    out_free;

   // multiplier cell chain, fed from the iterate registers
   assign ch_valid[0] = issue_ff;
   assign ch_x[0]     = x_ff;
   assign ch_y[0]     = y_ff;
   assign ch_xx[0]    = '0;
   assign ch_yy[0]    = '0;
   assign ch_xy[0]    = '0;

   for (genvar gi = 0; gi < NUM; gi++) begin : g_cell
      met_cell #(
         .WIDTH (XW),
         .INDEX (gi)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[gi]),
         .in_x      (ch_x[gi]),
         .in_y      (ch_y[gi]),
         .in_xx     (ch_xx[gi]),
         .in_yy     (ch_yy[gi]),
         .in_xy     (ch_xy[gi]),
         .out_valid (ch_valid[gi+1]),
         .out_x     (ch_x[gi+1]),
         .out_y     (ch_y[gi+1]),
         .out_xx    (ch_xx[gi+1]),
         .out_yy    (ch_yy[gi+1]),
         .out_xy    (ch_xy[gi+1])
      );
   end

   // floor rounding back to FRAC_BITS; 2xy folds into a shift one less
   always_comb begin
      sq_xx_full = ch_xx[NUM] >>> FRAC_BITS;
      sq_yy_full = ch_yy[NUM] >>> FRAC_BITS;
      xy2_full   = ch_xy[NUM] >>> (FRAC_BITS - 1);
      xx_w       = sq_xx_full[SW-1:0];
      yy_w       = sq_yy_full[SW-1:0];
      xy2_w      = xy2_full[SW:0];
      // squares of the current iterate double as the escape test
      sum_w      = SW1'(xx_w) + SW1'(yy_w);
      escape     = (sum_w > LIMIT);
      nx_w       = SW1'(xx_w) - SW1'(yy_w) + SW1'(cx_ff);
      ny_w       = xy2_w + SW1'(cy_ff);
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      issue_in      = 1'b0;
      max_iter_in   = max_iter_ff;
      k_in          = k_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_count_in  = rsp_count_ff;

      if (csr_valid) begin
         max_iter_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cx_in    = XW'($signed(req_tdata[31:0]));
               cy_in    = XW'($signed(req_tdata[63:32]));
               x_in     = '0;
               y_in     = '0;
               k_in     = '0;
               issue_in = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (ch_valid[NUM]) begin
               priority if (escape) begin
                  res_in   = {1'b0, k_ff} - ESC_BIAS;
                  state_in = ST_HOLD;
               end else if (k_ff == max_iter_ff) begin
                  res_in   = {1'b0, k_ff};
                  state_in = ST_HOLD;
               end else begin
                  x_in     = nx_w[XW-1:0];
                  y_in     = ny_w[XW-1:0];
                  k_in     = k_ff + 8'd1;
                  issue_in = 1'b1;
               end
               // skip the hold cycle when the output register is free
               if (state_in == ST_HOLD && out_free) begin
                  rsp_count_in  = res_in;
                  rsp_tvalid_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_count_in  = res_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         max_iter_ff   <= MAX_ITER_RESET;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         max_iter_ff   <= max_iter_in;
      end
      k_ff         <= k_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      res_ff       <= res_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff};

   `MET_ASSERT_NXT(a_accept_starts_pass, clock, reset, req_tvalid && req_tready,
                   issue_ff && (k_ff == 8'd0) && (state_ff == ST_RUN))
   `MET_ASSERT_IMP(a_one_pass_in_flight, clock, reset, 1'b1, $countones(ch_valid) <= 1)
   `MET_ASSERT_IMP(a_chain_quiet_off_run, clock, reset, state_ff != ST_RUN, ch_valid == '0)
   `MET_ASSERT_IMP(a_pass_within_limit, clock, reset, state_ff == ST_RUN,
                   k_ff <= max_iter_ff)

endmodule
